[design/crc8fme_pkg.sv]
// ----------------------------------------------------------------------------
// crc8fme_pkg
// shared types, constants and the crc-8 step for the framed message encoder
// ----------------------------------------------------------------------------
package crc8fme_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int MAX_LEN_W   = 16;

    localparam logic [7:0] MARK_START1 = 8'h23;
    localparam logic [7:0] MARK_START2 = 8'h21;
    localparam logic [7:0] MARK_END1   = 8'h2A;
    localparam logic [7:0] MARK_END2   = 8'h26;
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] CRC_INIT    = 8'h00;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 16'd1024;

    // slot positions within one burst of results
    typedef enum logic [2:0] {
        SLOT_START1 = 3'd0,
        SLOT_START2 = 3'd1,
        SLOT_LEN_HI = 3'd2,
        SLOT_LEN_LO = 3'd3,
        SLOT_BYTE   = 3'd4,
        SLOT_END1   = 3'd5,
        SLOT_CRC    = 3'd6,
        SLOT_END2   = 3'd7
    } slot_t;

    typedef struct packed {
        logic        has_results;
        slot_t       first_slot;
        slot_t       last_slot;
        logic        err;
        logic [7:0]  data;
        logic [15:0] len;
        logic [7:0]  crc_out;
    } burst_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[design/crc8fme_frame_ctrl.sv]
// ----------------------------------------------------------------------------
// crc8fme_frame_ctrl
// frame state, crc accumulator and length limit; builds the burst for an item
// ----------------------------------------------------------------------------
module crc8fme_frame_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic [7:0]             payload_byte,
    input  logic [15:0]            payload_length,
    input  logic                   last_byte,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_data,
    output crc8fme_pkg::burst_t    burst
);
    import crc8fme_pkg::*;

    logic                 in_frame_reg, in_frame_next;
    logic                 rejecting_reg, rejecting_next;
    logic [7:0]           crc_reg, crc_next;
    logic [MAX_LEN_W-1:0] max_len_reg, max_len_next;

    logic [LENGTH_BITS-1:0] len;
    logic                   start;
    logic                   rej;
    logic [7:0]             crc_new;

    assign len     = payload_length[LENGTH_BITS-1:0];
    assign start   = !in_frame_reg;
    assign rej     = start ? (MAX_LEN_W'(len) > max_len_reg) : rejecting_reg;
    assign crc_new = crc8_step(start ? CRC_INIT : crc_reg, payload_byte);

    always_comb begin
        burst.has_results = !rej || last_byte;
        burst.first_slot  = (start && !rej) ? SLOT_START1 : SLOT_BYTE;
        burst.last_slot   = (last_byte && !rej) ? SLOT_END2 : SLOT_BYTE;
        burst.err         = rej;
        burst.data        = payload_byte;
        burst.len         = 16'(len);
        burst.crc_out     = ~crc_new;
    end

    always_comb begin
        in_frame_next  = in_frame_reg;
        rejecting_next = rejecting_reg;
        crc_next       = crc_reg;
        max_len_next   = cfg_we ? cfg_data : max_len_reg;
        if (accept) begin
            in_frame_next  = !last_byte;
            rejecting_next = last_byte ? 1'b0 : rej;
            crc_next       = last_byte ? CRC_INIT : crc_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg  <= 1'b0;
            rejecting_reg <= 1'b0;
            crc_reg       <= CRC_INIT;
            max_len_reg   <= MAX_LEN_RESET;
        end else begin
            in_frame_reg  <= in_frame_next;
            rejecting_reg <= rejecting_next;
            crc_reg       <= crc_next;
            max_len_reg   <= max_len_next;
        end
    end

endmodule

[design/crc8fme_out_seq.sv]
// ----------------------------------------------------------------------------
// crc8fme_out_seq
// holds one burst and sends its results one per cycle while m_ready is high
// ----------------------------------------------------------------------------
module crc8fme_out_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  crc8fme_pkg::burst_t   burst,
    output logic                  can_load,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_last_of_run,
    output logic                  m_frame_error
);
    import crc8fme_pkg::*;

    burst_t burst_reg, burst_next;
    slot_t  slot_reg, slot_next;
    logic   busy_reg, busy_next;
    logic   at_last;

    assign at_last       = (slot_reg == burst_reg.last_slot);
    assign can_load      = !busy_reg || (m_ready && at_last);
    assign m_valid       = busy_reg;
    assign m_last_of_run = at_last;
    assign m_frame_error = burst_reg.err;

    always_comb begin
        unique case (slot_reg)
            SLOT_START1: m_out_byte = MARK_START1;
            SLOT_START2: m_out_byte = MARK_START2;
            SLOT_LEN_HI: m_out_byte = burst_reg.len[15:8];
            SLOT_LEN_LO: m_out_byte = burst_reg.len[7:0];
            SLOT_BYTE:   m_out_byte = burst_reg.err ? 8'h00 : burst_reg.data;
            SLOT_END1:   m_out_byte = MARK_END1;
            SLOT_CRC:    m_out_byte = burst_reg.crc_out;
            SLOT_END2:   m_out_byte = MARK_END2;
            default:     m_out_byte = 8'h00;
        endcase
    end

    always_comb begin
        burst_next = burst_reg;
        slot_next  = slot_reg;
        busy_next  = busy_reg;
        if (busy_reg && m_ready) begin
            if (at_last) begin
                busy_next = 1'b0;
            end else begin
                slot_next = slot_t'(slot_reg + 3'd1);
            end
        end
        if (load && burst.has_results) begin
            burst_next = burst;
            slot_next  = burst.first_slot;
            busy_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            slot_reg <= SLOT_BYTE;
        end else begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        burst_reg <= burst_next;
    end

endmodule

[design/crc8_framed_message_encoder.sv]
// output: the first result of an item is registered and shown in the cycle after
// it is accepted; results leave one per cycle while m_ready is high; an item causes
// 1 result as a plain byte, up to 8 for a one-byte frame, none when dropped and 1
// error result for the last byte of a dropped frame; the output burst register holds
// one item, and the next item enters when the output is idle or as its last result is taken
// reset: synchronous active-low aresetn clears frame state, crc and max_length=1024
// ----------------------------------------------------------------------------
// crc8_framed_message_encoder
// wraps payload bytes in a length-prefixed frame with a crc-8 trailer
// ----------------------------------------------------------------------------
module crc8_framed_message_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_payload_byte,
    input  logic [15:0] s_payload_length,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_of_run,
    output logic        m_frame_error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import crc8fme_pkg::*;

    burst_t burst;
    logic   accept;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    crc8fme_frame_ctrl u_frame_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .payload_byte   (s_payload_byte),
        .payload_length (s_payload_length),
        .last_byte      (s_last_byte),
        .cfg_we         (cfg_valid),
        .cfg_data       (cfg_data),
        .burst          (burst)
    );

    crc8fme_out_seq u_out_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept),
        .burst         (burst),
        .can_load      (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run),
        .m_frame_error (m_frame_error)
    );

endmodule

[design/crc8fme_checker.sv]
// ----------------------------------------------------------------------------
// crc8fme_checker
// port-level checks for the framed message encoder
// ----------------------------------------------------------------------------
module crc8fme_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_last_of_run,
    input logic        m_frame_error
);

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped while stalled");

    a_payload_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_byte) && $stable(m_last_of_run)
                                && $stable(m_frame_error))
        else $error("result changed while stalled");

    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_error |-> m_last_of_run && (m_out_byte == 8'h00))
        else $error("error result malformed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("item taken while results stalled");

endmodule

bind crc8_framed_message_encoder crc8fme_checker u_crc8fme_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_byte    (m_out_byte),
    .m_last_of_run (m_last_of_run),
    .m_frame_error (m_frame_error)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the crc-8 framed message encoder against a local frame predictor:
// directed frames at the length limits, then random frames under several limits
// with random idling and stalls on both channels
// ----------------------------------------------------------------------------
module tb;
    import crc8fme_pkg::*;

    localparam logic [7:0]  FRAME_OPEN_A  = 8'h23;
    localparam logic [7:0]  FRAME_OPEN_B  = 8'h21;
    localparam logic [7:0]  FRAME_CLOSE_A = 8'h2A;
    localparam logic [7:0]  FRAME_CLOSE_B = 8'h26;
    localparam logic [7:0]  CRC8_POLY     = 8'h07;
    localparam logic [15:0] LIMIT_AT_RESET = 16'd1024;
    localparam logic [15:0] LEN_MASK = 16'((32'd1 << LENGTH_BITS) - 1);
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last_of_run;
        logic       frame_error;
    } stream_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_payload_byte = 8'h00;
    logic [15:0] s_payload_length = 16'h0000;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last_of_run;
    logic        m_frame_error;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'h0000;

    // predictor state
    logic        enc_in_frame = 1'b0;
    logic        enc_rejecting = 1'b0;
    logic [7:0]  enc_crc = 8'h00;
    logic [15:0] enc_max_length = LIMIT_AT_RESET;

    stream_byte_t expected_stream[$];
    int  mismatch_count = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;
    int  rx_hold_cycles = 0;

    crc8_framed_message_encoder u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_payload_byte   (s_payload_byte),
        .s_payload_length (s_payload_length),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_last_of_run    (m_last_of_run),
        .m_frame_error    (m_frame_error),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        logic       msb;
        r = acc ^ b;
        repeat (8) begin
            msb = r[7];
            r = r << 1;
            if (msb) begin
                r = r ^ CRC8_POLY;
            end
        end
        return r;
    endfunction

    function automatic void push_stream_byte(input logic [7:0] data, input logic err);
        stream_byte_t sb;
        sb.data = data;
        sb.last_of_run = 1'b0;
        sb.frame_error = err;
        expected_stream.push_back(sb);
    endfunction

    // returns how many stream bytes the payload item causes
    function automatic int frame_encode(input logic [7:0] b, input logic [15:0] len_in,
                                        input logic last);
        int          n;
        logic [15:0] len;
        n = 0;
        len = len_in & LEN_MASK;
        if (!enc_in_frame) begin
            enc_in_frame = 1'b1;
            enc_crc = 8'h00;
            enc_rejecting = (len > enc_max_length);
            if (!enc_rejecting) begin
                push_stream_byte(FRAME_OPEN_A, 1'b0);
                push_stream_byte(FRAME_OPEN_B, 1'b0);
                push_stream_byte(len[15:8], 1'b0);
                push_stream_byte(len[7:0], 1'b0);
                n = 4;
            end
        end
        if (enc_rejecting) begin
            if (last) begin
                push_stream_byte(8'h00, 1'b1);
                n++;
            end
        end else begin
            push_stream_byte(b, 1'b0);
            enc_crc = crc8_update(enc_crc, b);
            n++;
            if (last) begin
                push_stream_byte(FRAME_CLOSE_A, 1'b0);
                push_stream_byte(~enc_crc, 1'b0);
                push_stream_byte(FRAME_CLOSE_B, 1'b0);
                n += 3;
            end
        end
        if (last) begin
            enc_in_frame = 1'b0;
            enc_rejecting = 1'b0;
            enc_crc = 8'h00;
        end
        if (n > 0) begin
            expected_stream[expected_stream.size() - 1].last_of_run = 1'b1;
        end
        return n;
    endfunction

    task automatic offer_payload_byte(input logic [7:0] b, input logic [15:0] len,
                                      input logic last, output int produced);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload_byte <= b;
        s_payload_length <= len;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        produced = frame_encode(b, len, last);
    endtask

    // returns the number of items in the frame that caused output
    task automatic send_frame(input int nbytes, input logic [15:0] len, output int active);
        int produced;
        active = 0;
        for (int i = 0; i < nbytes; i++) begin
            offer_payload_byte(8'($urandom), len, i == nbytes - 1, produced);
            if (produced > 0) begin
                active++;
            end
        end
    endtask

    task automatic wait_stream_idle();
        s_valid <= 1'b0;
        while (expected_stream.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_length(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        enc_max_length = value;
    endtask

    // receiver: random stalls per item, optional long hold-off
    initial begin
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            gap = rx_burst ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid && rx_hold_cycles == 0) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        stream_byte_t exp_b;
        if (aresetn && m_valid && m_ready) begin
            if (expected_stream.size() == 0) begin
                $error("unexpected item: out_byte %02h", m_out_byte);
                mismatch_count++;
            end else begin
                exp_b = expected_stream.pop_front();
                if (m_out_byte !== exp_b.data) begin
                    $error("out_byte expected %02h actual %02h", exp_b.data, m_out_byte);
                    mismatch_count++;
                end
                if (m_last_of_run !== exp_b.last_of_run) begin
                    $error("last_of_run expected %0b actual %0b",
                           exp_b.last_of_run, m_last_of_run);
                    mismatch_count++;
                end
                if (m_frame_error !== exp_b.frame_error) begin
                    $error("frame_error expected %0b actual %0b",
                           exp_b.frame_error, m_frame_error);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_default_limit();
        int p;
        offer_payload_byte(8'h00, 16'd1024, 1'b1, p);
        offer_payload_byte(8'hFF, 16'd1025, 1'b1, p);
        offer_payload_byte(8'h00, 16'd0, 1'b0, p);
        offer_payload_byte(8'hFF, 16'd0, 1'b0, p);
        offer_payload_byte(8'h5A, 16'd0, 1'b1, p);
        offer_payload_byte(8'h11, 16'hFFFF, 1'b0, p);
        offer_payload_byte(8'h22, 16'hFFFF, 1'b1, p);
        wait_stream_idle();
    endtask

    task automatic test_wide_limit();
        int p;
        write_max_length(16'hFFFF);
        offer_payload_byte(8'hFF, 16'hFFFF, 1'b0, p);
        offer_payload_byte(8'h80, 16'hFFFF, 1'b0, p);
        offer_payload_byte(8'h01, 16'hFFFF, 1'b1, p);
        wait_stream_idle();
    endtask

    task automatic test_zero_limit();
        int p;
        write_max_length(16'h0000);
        offer_payload_byte(8'hA5, 16'd0, 1'b1, p);
        offer_payload_byte(8'h12, 16'd1, 1'b0, p);
        offer_payload_byte(8'h34, 16'd1, 1'b1, p);
        wait_stream_idle();
    endtask

    // limit change inside a frame only applies from the next frame on
    task automatic test_limit_change_mid_frame();
        int p;
        write_max_length(LIMIT_AT_RESET);
        offer_payload_byte(8'h3C, 16'd500, 1'b0, p);
        offer_payload_byte(8'hC3, 16'd500, 1'b0, p);
        wait_stream_idle();
        write_max_length(16'd100);
        offer_payload_byte(8'h7E, 16'd500, 1'b1, p);
        offer_payload_byte(8'h01, 16'd500, 1'b1, p);
        offer_payload_byte(8'h02, 16'd100, 1'b1, p);
        wait_stream_idle();
    endtask

    task automatic test_output_backpressure();
        int active;
        write_max_length(LIMIT_AT_RESET);
        rx_hold_cycles = 300;
        tx_burst = 1'b1;
        send_frame(30, 16'd30, active);
        tx_burst = 1'b0;
        wait_stream_idle();
    endtask

    task automatic test_random_frames();
        logic [15:0] limits[5];
        logic [15:0] len;
        int          counted;
        int          active;
        int          nbytes;
        int          r;
        limits[0] = LIMIT_AT_RESET;
        limits[1] = 16'h0000;
        limits[2] = 16'hFFFF;
        limits[3] = 16'($urandom);
        limits[4] = 16'($urandom_range(0, 40));
        for (int ph = 0; ph < 5; ph++) begin
            wait_stream_idle();
            write_max_length(limits[ph]);
            counted = 0;
            while (counted < 80) begin
                if ($urandom_range(0, 5) == 0) begin
                    tx_burst = ~tx_burst;
                end
                if ($urandom_range(0, 5) == 0) begin
                    rx_burst = ~rx_burst;
                end
                nbytes = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 12);
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    len = 16'($urandom_range(0, enc_max_length));
                end else if (r < 75) begin
                    len = (enc_max_length == 16'hFFFF) ? 16'hFFFF : enc_max_length + 16'd1;
                end else if (r < 85) begin
                    len = 16'd0;
                end else begin
                    len = 16'($urandom);
                end
                send_frame(nbytes, len, active);
                counted += active;
                if ($urandom_range(0, 15) == 0) begin
                    wait_stream_idle();
                end
            end
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_limit();
        test_wide_limit();
        test_zero_limit();
        test_limit_change_mid_frame();
        test_output_backpressure();
        test_random_frames();
        wait_stream_idle();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[crc8_framed_message_encoder.f]
design/crc8fme_pkg.sv
design/crc8fme_frame_ctrl.sv
design/crc8fme_out_seq.sv
design/crc8_framed_message_encoder.sv
design/crc8fme_checker.sv
tb/tb.sv
